[rtl/core/sv39ptb_pkg.sv]
// ----------------------------------------------------------------------------
// Sv39 page table builder package
// Shared types and constants for the page table builder.
// ----------------------------------------------------------------------------
package sv39ptb_pkg;

  localparam int unsigned PPN_W   = 44;
  localparam int unsigned PTE_W   = 54;
  localparam int unsigned VA_W    = 39;
  localparam int unsigned PA_W    = 56;
  localparam int unsigned LEN_W   = 40;
  localparam int unsigned FLAGS_W = 10;
  localparam int unsigned VPN_W   = 9;
  localparam int unsigned PAGES_W = 28;
  localparam int unsigned ROOT_W  = 4;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_MAP     = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;
  localparam logic [1:0] REQ_RELEASE = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_FREE = 3'd1;
  localparam logic [2:0] ST_COVERED = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_KERNEL  = 3'd4;
  localparam logic [2:0] ST_UNUSED  = 3'd5;

  localparam logic CFG_BASE   = 1'b0;
  localparam logic CFG_KERNEL = 1'b1;

  localparam logic [FLAGS_W-1:0] F_V   = 10'h001;
  localparam logic [FLAGS_W-1:0] F_RWX = 10'h00E;
  localparam logic [FLAGS_W-1:0] F_AD  = 10'h0C0;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [ROOT_W-1:0]  root_table;
    logic [VPN_W-1:0]   entry_index;
    logic [VA_W-1:0]    virt_addr;
    logic [PA_W-1:0]    phys_addr;
    logic [LEN_W-1:0]   range_bytes;
    logic [FLAGS_W-1:0] leaf_perm;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [ROOT_W-1:0]  table_index;
    logic [PTE_W-1:0]   entry_value;
    logic [PAGES_W-1:0] pages_written;
  } out_item_t;

endpackage

[rtl/core/sv39_page_table_builder_unit.sv]
// ----------------------------------------------------------------------------
// Sv39 page table builder
// Builds three-level Sv39 tables in a private pool held in one memory.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake        | Payload
// in_     | input     | in_valid/stall   | in_item_t
// out_    | output    | out_valid/stall  | out_item_t
// cfg_    | input     | cfg_valid/ready  | index, 44-bit data
//
// One item at a time. The table memory is read one entry per cycle through a
// registered read port, so cost follows memory accesses: allocate sweeps the
// new table clear, read does one access, map does a page step per page plus a
// read per pointer level and one write for the leaf, plus a clearing sweep and
// pointer write per table allocated; release scans every entry of the root and
// level-1 tables in the tree. Reset clears only the in-use bits, the state, the
// configuration and the result valid; the memory holds no reset.
// A finished result can sit in the output register while the next item enters.
module sv39_page_table_builder_unit
  import sv39ptb_pkg::*;
#(
  parameter int unsigned POOL_TABLES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [PPN_W-1:0] cfg_data
);

  localparam int unsigned TW = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int unsigned AW = TW + VPN_W;

  typedef enum logic [3:0] {
    S_IDLE, S_ALLOC_CLR, S_MAP_STEP, S_MAP_RD, S_MAP_CHK, S_MAP_NEWCLR,
    S_MAP_LINK, S_READ_RD, S_READ_DONE, S_REL_RD, S_REL_CHK, S_DONE
  } state_t;

  logic [PTE_W-1:0] mem [0:(1<<AW)-1];
  logic [PTE_W-1:0] rdata_r;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [PTE_W-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  state_t             state_r;
  logic [POOL_TABLES-1:0] inuse_r;
  logic [PPN_W-1:0]   base_r;
  logic [ROOT_W-1:0]  kroot_r;
  in_item_t           req_r;
  out_item_t          res_r;
  logic               res_v_r;
  logic [TW-1:0]      tbl_r;        // table being walked / cleared
  logic [VPN_W-1:0]   idx_r;        // sweep counter
  logic [1:0]         lvl_r;        // current walk level
  logic [1:0]         tgt_r;        // leaf level of this step
  logic [VA_W:0]      va_r, end_r;
  logic [PA_W-1:0]    pa_r;
  logic [PAGES_W-1:0] pages_r;
  logic [AW-1:0]      slot_r;       // entry being linked on allocation
  // release stack: table and index of the root level while a level-1 table is scanned
  logic [TW-1:0]      stk_t_r;
  logic [VPN_W-1:0]   stk_i_r;
  logic               depth_r;      // 0 = root level, 1 = level 1

  // Lowest free table, found by priority search.
  logic [TW-1:0] free_t;
  logic          free_ok;
  always_comb begin
    free_t  = '0;
    free_ok = 1'b0;
    for (int i = POOL_TABLES - 1; i >= 0; i--) begin
      if (!inuse_r[i]) begin
        free_t  = TW'(i);
        free_ok = 1'b1;
      end
    end
  end

  logic [ROOT_W-1:0] in_root;
  logic              root_ok;
  assign in_root = in_item.root_table;
  assign root_ok = ({28'd0, in_root} < 32'(POOL_TABLES)) && inuse_r[TW'(in_root)];

  function automatic logic [VPN_W-1:0] vpn(input logic [VA_W:0] va, input logic [1:0] l);
    logic [VPN_W-1:0] v;
    unique case (l)
      2'd2:    v = va[38:30];
      2'd1:    v = va[29:21];
      default: v = va[20:12];
    endcase
    return v;
  endfunction

  // Leaf level choice: both addresses aligned and enough length remaining.
  logic [VA_W:0] remain;
  logic [1:0]    pick;
  always_comb begin
    remain = end_r - va_r;
    if (va_r[29:0] == '0 && pa_r[29:0] == '0 && remain >= (40'd1 << 30))
      pick = 2'd2;
    else if (va_r[20:0] == '0 && pa_r[20:0] == '0 && remain >= (40'd1 << 21))
      pick = 2'd1;
    else
      pick = 2'd0;
  end

  // Table number named by the entry just read.
  logic [PPN_W-1:0] ptr_off;
  logic             ptr_in;
  assign ptr_off = rdata_r[PTE_W-1:10] - base_r;
  assign ptr_in  = ptr_off < PPN_W'(POOL_TABLES);

  logic [VA_W:0] step_sz;
  always_comb begin
    unique case (tgt_r)
      2'd2:    step_sz = 40'd1 << 30;
      2'd1:    step_sz = 40'd1 << 21;
      default: step_sz = 40'd1 << 12;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE) || (res_v_r && out_stall);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = res_v_r;
  assign out_item  = res_r;

  logic [PTE_W-1:0] link_pte;
  assign link_pte = PTE_W'({base_r + PPN_W'(tbl_r), 10'd0} | 54'(F_V));

  always_comb begin
    we    = 1'b0;
    waddr = {tbl_r, idx_r};
    wdata = '0;
    raddr = {tbl_r, vpn(va_r, lvl_r)};
    unique case (state_r)
      S_ALLOC_CLR, S_MAP_NEWCLR: we = 1'b1;
      S_MAP_LINK: begin
        we    = 1'b1;
        waddr = slot_r;
        wdata = link_pte;
      end
      S_MAP_CHK: begin
        if (lvl_r == tgt_r) begin
          we    = 1'b1;
          waddr = {tbl_r, vpn(va_r, lvl_r)};
          wdata = PTE_W'({pa_r[PA_W-1:12], 10'd0} | {44'd0, req_r.leaf_perm | F_V | F_AD});
        end
      end
      S_READ_RD:  raddr = {tbl_r, req_r.entry_index};
      S_REL_RD:   raddr = {tbl_r, idx_r};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      inuse_r   <= '0;
      base_r    <= '0;
      kroot_r   <= '0;
      res_v_r   <= 1'b0;
    end else begin
      if (res_v_r && !out_stall) res_v_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BASE) base_r <= cfg_data;
        else                       kroot_r <= cfg_data[ROOT_W-1:0];
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req_r   <= in_item;
            res_r   <= '0;
            pages_r <= '0;
            idx_r   <= '0;
            tbl_r   <= TW'(in_root);
            va_r    <= {1'b0, in_item.virt_addr};
            pa_r    <= in_item.phys_addr;
            end_r   <= {1'b0, in_item.virt_addr} + in_item.range_bytes;
            depth_r <= 1'b0;
            unique case (in_item.req_type)
              REQ_ALLOC: begin
                if (free_ok) begin
                  inuse_r[free_t] <= 1'b1;
                  tbl_r <= free_t;
                  res_r.table_index <= ROOT_W'(free_t);
                  state_r <= S_ALLOC_CLR;
                end else begin
                  res_r.status <= ST_NO_FREE;
                  state_r <= S_DONE;
                end
              end
              REQ_MAP: begin
                if (!root_ok) begin
                  res_r.status <= ST_UNUSED; state_r <= S_DONE;
                end else if (({2'b0, in_item.virt_addr} + {1'b0, in_item.range_bytes}) >
                             (41'd1 << 39)) begin
                  res_r.status <= ST_RANGE; state_r <= S_DONE;
                end else state_r <= S_MAP_STEP;
              end
              REQ_READ: begin
                if (!root_ok) begin
                  res_r.status <= ST_UNUSED; state_r <= S_DONE;
                end else state_r <= S_READ_RD;
              end
              default: begin
                if (in_root == kroot_r) begin
                  res_r.status <= ST_KERNEL; state_r <= S_DONE;
                end else if (!root_ok) begin
                  res_r.status <= ST_UNUSED; state_r <= S_DONE;
                end else state_r <= S_REL_RD;
              end
            endcase
          end
        end
        S_ALLOC_CLR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == '1) state_r <= S_DONE;
        end
        S_MAP_STEP: begin
          if (va_r >= end_r) begin
            res_r.pages_written <= pages_r;
            state_r <= S_DONE;
          end else begin
            tbl_r <= TW'(req_r.root_table);
            lvl_r <= 2'd2;
            tgt_r <= pick;
            state_r <= (pick == 2'd2) ? S_MAP_CHK : S_MAP_RD;
          end
        end
        S_MAP_RD: state_r <= S_MAP_CHK;
        S_MAP_CHK: begin
          if (lvl_r == tgt_r) begin
            pages_r <= pages_r + 1'b1;
            va_r    <= va_r + step_sz;
            pa_r    <= pa_r + PA_W'(step_sz);
            state_r <= S_MAP_STEP;
          end else if (!rdata_r[0]) begin
            if (free_ok) begin
              inuse_r[free_t] <= 1'b1;
              slot_r  <= {tbl_r, vpn(va_r, lvl_r)};
              tbl_r   <= free_t;
              idx_r   <= '0;
              state_r <= S_MAP_NEWCLR;
            end else begin
              res_r.status <= ST_NO_FREE;
              res_r.pages_written <= pages_r;
              state_r <= S_DONE;
            end
          end else if ((rdata_r[9:0] & F_RWX) != '0) begin
            res_r.status <= ST_COVERED;
            res_r.pages_written <= pages_r;
            state_r <= S_DONE;
          end else if (!ptr_in) begin
            res_r.status <= ST_UNUSED;
            res_r.pages_written <= pages_r;
            state_r <= S_DONE;
          end else begin
            tbl_r <= TW'(ptr_off);
            lvl_r <= lvl_r - 1'b1;
            state_r <= (lvl_r - 2'd1 == tgt_r) ? S_MAP_CHK : S_MAP_RD;
          end
        end
        S_MAP_NEWCLR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == '1) begin
            lvl_r <= lvl_r - 1'b1;
            state_r <= S_MAP_LINK;
          end
        end
        // The pointer to the freshly cleared table is written here, in a state of its own.
        S_MAP_LINK: state_r <= (lvl_r == tgt_r) ? S_MAP_CHK : S_MAP_RD;
        S_READ_RD: state_r <= S_READ_DONE;
        S_READ_DONE: begin
          res_r.entry_value <= rdata_r;
          state_r <= S_DONE;
        end
        S_REL_RD: state_r <= S_REL_CHK;
        S_REL_CHK: begin
          if (rdata_r[0] && (rdata_r[9:0] & F_RWX) == '0 && ptr_in) begin
            if (!depth_r) begin
              stk_t_r <= tbl_r;
              stk_i_r <= idx_r;
              depth_r <= 1'b1;
              tbl_r <= TW'(ptr_off);
              idx_r <= '0;
              state_r <= S_REL_RD;
            end else begin
              // level-0 tables hold only leaves to free, no scan needed
              inuse_r[TW'(ptr_off)] <= 1'b0;
              idx_r <= idx_r + 1'b1;
              state_r <= (idx_r == '1) ? S_REL_CHK : S_REL_RD;
              if (idx_r == '1) begin
                inuse_r[tbl_r] <= 1'b0;
                tbl_r <= stk_t_r;
                idx_r <= stk_i_r + 1'b1;
                depth_r <= 1'b0;
                state_r <= (stk_i_r == '1) ? S_DONE : S_REL_RD;
                if (stk_i_r == '1) inuse_r[stk_t_r] <= 1'b0;
              end
            end
          end else if (idx_r == '1) begin
            inuse_r[tbl_r] <= 1'b0;
            if (depth_r) begin
              tbl_r <= stk_t_r;
              idx_r <= stk_i_r + 1'b1;
              depth_r <= 1'b0;
              state_r <= (stk_i_r == '1) ? S_DONE : S_REL_RD;
              if (stk_i_r == '1) inuse_r[stk_t_r] <= 1'b0;
            end else state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_REL_RD;
          end
        end
        S_DONE: begin
          if (!res_v_r || !out_stall) begin
            res_v_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Input is only taken from idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> state_r == S_IDLE)
    else $error("item accepted while busy");
  // A result is raised only from the done state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_v_r) |-> $past(state_r) == S_DONE)
    else $error("result without done state");
  // Configuration never lands mid-request.
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> state_r == S_IDLE)
    else $error("config ready while busy");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sv39 page table builder testbench
// Drives allocate, map, read and release requests through the item channel
// and checks every result against a page table tracker that mirrors the
// table pool. All pool tables are allocated once after reset so that no
// entry is ever read before it has been written.
// ----------------------------------------------------------------------------
module testbench;
  import sv39ptb_pkg::*;

  localparam int unsigned POOL    = 16;
  localparam int unsigned ENTRIES = 512;
  localparam int unsigned WATCHDOG_LIMIT = 300000;
  localparam logic [63:0] M44 = 64'hFFF_FFFF_FFFF;
  localparam logic [63:0] M56 = 64'hFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VA_TOP = 64'd1 << 39;

  class page_table_tracker;
    logic [PTE_W-1:0] pool_mem [POOL*ENTRIES];
    bit               in_use [POOL];
    logic [PPN_W-1:0] base_ppn;
    logic [3:0]       kernel_tbl;
    out_item_t        pending_replies [$];
    int               errors;

    function new();
      foreach (pool_mem[i]) pool_mem[i] = '0;
      foreach (in_use[i]) in_use[i] = 0;
      base_ppn = '0;
      kernel_tbl = '0;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [PPN_W-1:0] data);
      if (idx == CFG_BASE) base_ppn = data;
      else kernel_tbl = data[3:0];
    endfunction

    function int table_of(logic [PTE_W-1:0] pte);
      logic [PPN_W-1:0] t;
      t = pte[PTE_W-1:10] - base_ppn;
      return (t < POOL) ? int'(t) : POOL;
    endfunction

    function int grab_table();
      for (int t = 0; t < POOL; t++) begin
        if (!in_use[t]) begin
          in_use[t] = 1;
          for (int i = 0; i < ENTRIES; i++) pool_mem[t*ENTRIES+i] = '0;
          return t;
        end
      end
      return POOL;
    endfunction

    function void free_tree(int t, int level);
      logic [PTE_W-1:0] pte;
      int nt;
      if (level > 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          pte = pool_mem[t*ENTRIES+i];
          if (!pte[0] || (pte[9:0] & F_RWX) != 0) continue;
          nt = table_of(pte);
          if (nt < POOL) free_tree(nt, level - 1);
        end
      end
      in_use[t] = 0;
    endfunction

    function logic [2:0] map_range(int root, logic [63:0] va, logic [63:0] pa,
                                   logic [63:0] len, logic [9:0] flags,
                                   output logic [PAGES_W-1:0] pages);
      logic [63:0] stop_va, sz, leaf;
      int level, t, nt, slot;
      stop_va = va + len;
      pages = '0;
      while (va < stop_va) begin
        level = 2;
        while (level > 0) begin
          sz = 64'd1 << (12 + 9 * level);
          if ((va & (sz - 1)) == 0 && (pa & (sz - 1)) == 0 && stop_va - va >= sz) break;
          level--;
        end
        t = root;
        for (int l = 2; l > level; l--) begin
          slot = t * ENTRIES + int'((va >> (12 + 9 * l)) & 64'h1FF);
          if (!pool_mem[slot][0]) begin
            nt = grab_table();
            if (nt >= POOL) return ST_NO_FREE;
            pool_mem[slot] = {base_ppn + PPN_W'(nt), F_V};
          end else if ((pool_mem[slot][9:0] & F_RWX) != 0) begin
            return ST_COVERED;
          end
          t = table_of(pool_mem[slot]);
          if (t >= POOL) return ST_UNUSED;
        end
        leaf = ((pa >> 12) << 10) | 64'(flags) | 64'(F_V) | 64'(F_AD);
        pool_mem[t*ENTRIES + int'((va >> (12 + 9 * level)) & 64'h1FF)] = leaf[PTE_W-1:0];
        pages++;
        sz = 64'd1 << (12 + 9 * level);
        va += sz;
        pa = (pa + sz) & M56;
      end
      return ST_OK;
    endfunction

    function void note_request(in_item_t r);
      out_item_t e;
      bit root_ok;
      int t;
      e = '0;
      root_ok = in_use[r.root_table];
      case (r.req_type)
        REQ_ALLOC: begin
          t = grab_table();
          if (t >= POOL) e.status = ST_NO_FREE;
          else e.table_index = t[3:0];
        end
        REQ_MAP: begin
          if (!root_ok) e.status = ST_UNUSED;
          else if (64'(r.virt_addr) + 64'(r.range_bytes) > VA_TOP) e.status = ST_RANGE;
          else e.status = map_range(r.root_table, 64'(r.virt_addr), 64'(r.phys_addr),
                                    64'(r.range_bytes), r.leaf_perm, e.pages_written);
        end
        REQ_READ: begin
          if (!root_ok) e.status = ST_UNUSED;
          else e.entry_value = pool_mem[r.root_table*ENTRIES + r.entry_index];
        end
        default: begin
          if (r.root_table == kernel_tbl) e.status = ST_KERNEL;
          else if (!root_ok) e.status = ST_UNUSED;
          else free_tree(r.root_table, 2);
        end
      endcase
      pending_replies.push_back(e);
    endfunction

    function void check_result(out_item_t a);
      out_item_t e;
      if (pending_replies.size() == 0) begin
        $error("result item with none expected: status %0d", a.status);
        errors++;
        return;
      end
      e = pending_replies.pop_front();
      if (a.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, a.status);
        errors++;
      end
      if (a.table_index !== e.table_index) begin
        $error("table_index: expected %0d, got %0d", e.table_index, a.table_index);
        errors++;
      end
      if (a.entry_value !== e.entry_value) begin
        $error("entry_value: expected %h, got %h", e.entry_value, a.entry_value);
        errors++;
      end
      if (a.pages_written !== e.pages_written) begin
        $error("pages_written: expected %0d, got %0d", e.pages_written, a.pages_written);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_item;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [PPN_W-1:0] cfg_data;

  page_table_tracker tracker;
  int  items_sent;
  bit  calm;
  bit  pressure_done;
  bit  moved;
  int  quiet_cycles;

  sv39_page_table_builder_unit #(.POOL_TABLES(POOL)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Idling pauses during every fourth stretch of items and near the end.
  function bit idling_allowed();
    return !calm && ((items_sent / 150) % 4 != 3);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      moved = 0;
      if (in_valid && !in_stall) begin
        tracker.note_request(in_item);
        moved = 1;
      end
      if (out_valid && !out_stall) begin
        tracker.check_result(out_item);
        moved = 1;
      end
      if (cfg_valid && cfg_ready) begin
        tracker.write_reg(cfg_index, cfg_data);
        moved = 1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off so the block backs up.
  initial begin
    int hold;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!pressure_done && items_sent >= 300) begin
        out_stall <= 1'b1;
        hold = 400;
        pressure_done = 1;
      end else if (idling_allowed() && $urandom_range(3) == 0) begin
        out_stall <= 1'b1;
        hold = $urandom_range(12);
      end else begin
        out_stall <= 1'b0;
        hold = $urandom_range(20);
      end
    end
  end

  task automatic send_item(in_item_t r);
    in_valid <= 1'b1;
    in_item  <= r;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_paced(in_item_t r);
    if (idling_allowed() && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    send_item(r);
  endtask

  task automatic write_reg(logic idx, logic [PPN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Waits for the next clock edge first so that the monitor has noted the last item sent.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic in_item_t make_req(logic [1:0] kind, int root, int idx,
                                        logic [63:0] va, logic [63:0] pa,
                                        logic [63:0] len, logic [9:0] flags);
    in_item_t r;
    r.req_type    = kind;
    r.root_table  = root[3:0];
    r.entry_index = idx[8:0];
    r.virt_addr   = va[VA_W-1:0];
    r.phys_addr   = pa[PA_W-1:0];
    r.range_bytes = len[LEN_W-1:0];
    r.leaf_perm   = flags;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_root();
    int live [$];
    if ($urandom_range(9) == 0) return $urandom_range(15);
    for (int t = 0; t < POOL; t++) if (tracker.in_use[t]) live.push_back(t);
    if (live.size() == 0) return $urandom_range(15);
    return live[$urandom_range(live.size() - 1)];
  endfunction

  function automatic in_item_t random_request();
    in_item_t r;
    logic [63:0] va, pa, len, sz;
    int live_cnt, roll, lv;
    r = make_req(2'($urandom_range(3)), $urandom_range(15), $urandom_range(511),
                 rand64(), rand64(), rand64(), 10'($urandom_range(1023)));
    live_cnt = 0;
    for (int t = 0; t < POOL; t++) live_cnt += tracker.in_use[t];
    roll = $urandom_range(99);
    if (live_cnt >= 12) roll = (roll < 10) ? 0 : (roll < 50) ? 1 : (roll < 70) ? 2 : 3;
    else roll = (roll < 22) ? 0 : (roll < 70) ? 1 : (roll < 90) ? 2 : 3;
    case (roll)
      0: r.req_type = REQ_ALLOC;
      1: begin
        r.req_type = REQ_MAP;
        r.root_table = 4'(pick_root());
        roll = $urandom_range(99);
        lv = (roll < 50) ? 0 : (roll < 80) ? 1 : 2;
        sz = 64'd1 << (12 + 9 * lv);
        va = rand64() & (VA_TOP - 1) & ~(sz - 1);
        pa = rand64() & M56 & ~(sz - 1);
        len = sz * $urandom_range(1, (lv == 2) ? 8 : 4);
        if ($urandom_range(3) == 0) len += $urandom_range(1, 4095);
        if (lv == 0 && $urandom_range(9) == 0) begin
          va |= $urandom_range(4095);
          pa |= $urandom_range(4095);
        end
        // Oversized lengths always run past the address space.
        if ($urandom_range(32) == 0) begin
          len = rand64() & 64'hFF_FFFF_FFFF;
          len[39] = 1'b1;
          if (va == 0) va = 64'd1;
        end
        r.virt_addr = va[VA_W-1:0];
        r.phys_addr = pa[PA_W-1:0];
        r.range_bytes = len[LEN_W-1:0];
        if ($urandom_range(6) != 0 && (r.leaf_perm & F_RWX) == 0)
          r.leaf_perm = r.leaf_perm | 10'h002;
      end
      2: begin
        r.req_type = REQ_READ;
        r.root_table = 4'(pick_root());
      end
      default: begin
        r.req_type = REQ_RELEASE;
        r.root_table = ($urandom_range(9) == 0) ? tracker.kernel_tbl : 4'(pick_root());
      end
    endcase
    return r;
  endfunction

  task automatic run_directed();
    logic [63:0] gig;
    gig = 64'd1 << 30;
    // Fill the whole pool once so every entry has been zeroed.
    for (int i = 0; i <= POOL; i++) send_item(make_req(REQ_ALLOC, 0, 0, 0, 0, 0, 0));
    for (int t = POOL - 1; t >= 0; t--) send_item(make_req(REQ_RELEASE, t, 0, 0, 0, 0, 0));
    send_item(make_req(REQ_ALLOC, 0, 0, 0, 0, 0, 0));
    send_item(make_req(REQ_MAP, 1, 0, 0, 0, gig, 10'h00E));
    send_item(make_req(REQ_MAP, 1, 0, 4096, 4096, 4096, 10'h00E));
    send_item(make_req(REQ_READ, 1, 0, 0, 0, 0, 0));
    send_item(make_req(REQ_MAP, 1, 0, gig, 64'h123_4567_8000, 5000, 10'h3FF));
    send_item(make_req(REQ_READ, 1, 1, 0, 0, 0, 0));
    send_item(make_req(REQ_MAP, 1, 0, 64'h7FFF, 64'h1234, 0, 10'h002));
    send_item(make_req(REQ_MAP, 1, 0, VA_TOP - 4096, 0, 8192, 10'h002));
    send_item(make_req(REQ_MAP, 1, 0, VA_TOP - 8192, M56 - 4095, 8192, 10'h002));
    // A leaf with no R, W or X whose page number lands on pool table zero.
    send_item(make_req(REQ_MAP, 1, 0, 2 * gig, 0, gig, 10'h010));
    send_item(make_req(REQ_MAP, 1, 0, 2 * gig + 4096, 4096, 4096, 10'h002));
    send_item(make_req(REQ_MAP, 1, 0, 3 * gig, 64'd1 << 50, gig, 10'h020));
    send_item(make_req(REQ_MAP, 1, 0, 3 * gig + (64'd2 << 20), 0, 64'd2 << 20, 10'h004));
    send_item(make_req(REQ_READ, 15, 511, 0, 0, 0, 0));
    send_item(make_req(REQ_MAP, 9, 0, 0, 0, 4096, 10'h002));
    send_item(make_req(REQ_RELEASE, 0, 0, 0, 0, 0, 0));
    send_item(make_req(REQ_ALLOC, 0, 0, 0, 0, 0, 0));
    send_item(make_req(REQ_MAP, 5, 0, 0, 64'd1 << 55, VA_TOP, 10'h3FF));
    send_item(make_req(REQ_READ, 5, 511, 0, 0, 0, 0));
    send_item(make_req(REQ_RELEASE, 5, 0, 0, 0, 0, 0));
    send_item(make_req(REQ_RELEASE, 1, 0, 0, 0, 0, 0));
    send_item(make_req(REQ_RELEASE, 1, 0, 0, 0, 0, 0));
  endtask

  initial begin
    logic [PPN_W-1:0] base_pick;
    logic [3:0] kernel_pick;
    tracker = new();
    items_sent = 0;
    calm = 0;
    pressure_done = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_BASE;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin base_pick = '0; kernel_pick = '0; end
        1: begin base_pick = '1; kernel_pick = 4'd15; end
        2: begin
          base_pick = PPN_W'(rand64());
          kernel_pick = 4'($urandom_range(15));
        end
        default: begin
          base_pick = PPN_W'($urandom_range(1, 4000));
          kernel_pick = 4'($urandom_range(15));
        end
      endcase
      write_reg(CFG_BASE, base_pick);
      write_reg(CFG_KERNEL, PPN_W'(kernel_pick));
      cfg_valid <= 1'b0;
      @(posedge clk);
      if (phase == 0) run_directed();
      for (int i = 0; i < 300; i++) begin
        if (phase == 3 && i >= 150) calm = 1;
        send_paced(random_request());
      end
    end
    wait_drained();
    repeat (50) @(posedge clk);
    if (tracker.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[files.f]
rtl/core/sv39ptb_pkg.sv
rtl/core/sv39_page_table_builder_unit.sv
tb/sv/testbench.sv
